[design/tprs_pkg.sv]
package tprs_pkg;

    localparam int RUN_DEPTH = 64;
    localparam int CNT_W     = $clog2(RUN_DEPTH + 1);
    localparam int LIM_W     = 7;
    localparam int THR_W     = 8;
    localparam int GRAY_W    = 8;
    localparam int PIX_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(128);
    localparam logic [LIM_W-1:0] MAX_RUN_RESET   = LIM_W'(50);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_MAX_RUN   = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_argb;
        logic             row_end;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_pixel;
        logic             last_of_burst;
        logic             out_row_end;
    } out_item_t;

    // one slot of the sort chain
    typedef struct packed {
        logic              valid;
        logic [GRAY_W-1:0] gray;
        logic [PIX_W-1:0]  pixel;
    } slot_t;

    // broadcast from the control to every cell
    typedef struct packed {
        logic  insert;
        logic  shift;
        slot_t new_slot;
    } cell_ctrl_t;

    // (r*11 + g*16 + b*5) / 32, truncated
    function automatic logic [GRAY_W-1:0] gray_of(input logic [PIX_W-1:0] p);
        logic [12:0] sum;
        sum = 13'(p[23:16]) * 13'd11 + 13'(p[15:8]) * 13'd16 + 13'(p[7:0]) * 13'd5;
        return sum[12:5];
    endfunction

endpackage

[design/tprs_cell.sv]
module tprs_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tprs_pkg::cell_ctrl_t   ctrl,
    input  tprs_pkg::slot_t        left_slot,
    input  logic                   left_gt,
    input  tprs_pkg::slot_t        right_slot,
    output tprs_pkg::slot_t        cell_slot,
    output logic                   cell_gt
);

    tprs_pkg::slot_t slot_reg;
    tprs_pkg::slot_t slot_next;

    // empty slots count as greater, so a new pixel lands after all equal keys
    assign cell_gt   = !slot_reg.valid || (slot_reg.gray > ctrl.new_slot.gray);
    assign cell_slot = slot_reg;

    always_comb begin
        slot_next = slot_reg;
        if (ctrl.shift) begin
            slot_next = right_slot;
        end else if (ctrl.insert && cell_gt) begin
            slot_next = left_gt ? left_slot : ctrl.new_slot;
        end
    end

    // only the valid bit needs a reset; key and pixel follow it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else begin
            slot_reg.valid <= slot_next.valid;
        end
        slot_reg.gray  <= slot_next.gray;
        slot_reg.pixel <= slot_next.pixel;
    end

endmodule

[design/threshold_pixel_run_sorter.sv]
// Pass-through pixel: result valid in the cycle after the input transfer.
// Run pixels: taken 1 per cycle while s_ready is high and sorted on arrival; the first sorted
// result is registered after the state moves to emitting, then 1 result per cycle while the
// output is free. Input is held off meanwhile: the run leaves through cell 0 of the chain only.
// Reset (aresetn low, synchronous): no open run, chain empty, output empty,
// threshold 128, run limit 50.
module threshold_pixel_run_sorter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tprs_pkg::in_item_t                  s_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tprs_pkg::out_item_t                 m_payload,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tprs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tprs_pkg::CFG_DAT_W-1:0]      cfg_wdata
);

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'b01,
        ST_EMIT   = 2'b10
    } state_t;

    state_t                          state_reg, state_next;
    logic [tprs_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                            rend_reg, rend_next;
    logic [tprs_pkg::THR_W-1:0]      thr_reg;
    logic [tprs_pkg::LIM_W-1:0]      mrl_reg;
    logic                            m_valid_reg, m_valid_next;
    tprs_pkg::out_item_t             m_payload_reg, m_payload_next;

    logic                            out_free;
    logic                            in_xfer;
    logic [tprs_pkg::GRAY_W-1:0]     in_gray;
    logic                            bright;
    logic                            pass_thru;
    logic                            ins;
    logic                            close_run;
    logic                            emit_step;
    logic                            emit_last;
    logic [tprs_pkg::CNT_W-1:0]      cnt_inc;
    logic [tprs_pkg::LIM_W-1:0]      lim;
    tprs_pkg::cell_ctrl_t            ctrl;

    tprs_pkg::slot_t                 cell_q  [tprs_pkg::RUN_DEPTH];
    logic                            cell_gt [tprs_pkg::RUN_DEPTH];

    // ---------------- configuration: always ready, takes effect next transfer
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= tprs_pkg::THRESHOLD_RESET;
            mrl_reg <= tprs_pkg::MAX_RUN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                tprs_pkg::REG_THRESHOLD: thr_reg <= cfg_wdata[tprs_pkg::THR_W-1:0];
                tprs_pkg::REG_MAX_RUN:   mrl_reg <= cfg_wdata[tprs_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // effective limit: zero acts as one, anything above the chain length saturates
    always_comb begin
        if (mrl_reg == '0) begin
            lim = tprs_pkg::LIM_W'(1);
        end else if (mrl_reg > tprs_pkg::LIM_W'(tprs_pkg::RUN_DEPTH)) begin
            lim = tprs_pkg::LIM_W'(tprs_pkg::RUN_DEPTH);
        end else begin
            lim = mrl_reg;
        end
    end

    // ---------------- input decode
    // output register must be free (or draining) so a pass-through can land
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_ACCEPT) && out_free;
    assign in_xfer   = s_valid && s_ready;
    assign in_gray   = tprs_pkg::gray_of(s_payload.pixel_argb);
    assign bright    = in_gray > thr_reg;
    assign pass_thru = in_xfer && (count_reg == '0) && !bright;
    assign ins       = in_xfer && !pass_thru;
    // count_reg stays below RUN_DEPTH while accepting, so no overflow here
    assign cnt_inc   = count_reg + tprs_pkg::CNT_W'(1);
    // closing pixel is part of the run; run also closes on row end or length limit
    assign close_run = ins && (!bright || s_payload.row_end
                               || tprs_pkg::LIM_W'(cnt_inc) >= lim
                               || cnt_inc == tprs_pkg::CNT_W'(tprs_pkg::RUN_DEPTH));

    // ---------------- emission: chain shifts toward cell 0, one pixel per transfer
    assign emit_step = (state_reg == ST_EMIT) && out_free;
    assign emit_last = count_reg == tprs_pkg::CNT_W'(1);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        rend_next  = rend_reg;
        case (state_reg)
            ST_ACCEPT: begin
                if (ins) begin
                    count_next = cnt_inc;
                end
                if (close_run) begin
                    state_next = ST_EMIT;
                    rend_next  = s_payload.row_end;
                end
            end
            ST_EMIT: begin
                if (emit_step) begin
                    count_next = count_reg - tprs_pkg::CNT_W'(1);
                    if (emit_last) begin
                        state_next = ST_ACCEPT;
                    end
                end
            end
            default: begin
                state_next = ST_ACCEPT;
                count_next = '0;
            end
        endcase
    end

    // ---------------- output register
    always_comb begin
        m_payload_next = m_payload_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        if (pass_thru) begin
            m_valid_next                 = 1'b1;
            m_payload_next.out_pixel     = s_payload.pixel_argb;
            m_payload_next.last_of_burst = 1'b1;
            m_payload_next.out_row_end   = s_payload.row_end;
        end else if (emit_step) begin
            m_valid_next                 = 1'b1;
            m_payload_next.out_pixel     = cell_q[0].pixel;
            m_payload_next.last_of_burst = emit_last;
            m_payload_next.out_row_end   = emit_last && rend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCEPT;
            count_reg   <= '0;
            rend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rend_reg    <= rend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // ---------------- insertion sort chain
    // Every cell compares its key with the broadcast pixel; cells holding a larger
    // key (or empty) move one place right, the first of them takes the new pixel.
    assign ctrl.insert         = ins;
    assign ctrl.shift          = emit_step;
    assign ctrl.new_slot.valid = 1'b1;
    assign ctrl.new_slot.gray  = in_gray;
    assign ctrl.new_slot.pixel = s_payload.pixel_argb;

    for (genvar i = 0; i < tprs_pkg::RUN_DEPTH; i++) begin : g_cell
        tprs_pkg::slot_t left_slot;
        tprs_pkg::slot_t right_slot;
        logic            left_gt;

        if (i == 0) begin : g_head
            assign left_slot = '0;
            assign left_gt   = 1'b0;
        end else begin : g_body
            assign left_slot = cell_q[i-1];
            assign left_gt   = cell_gt[i-1];
        end

        if (i == tprs_pkg::RUN_DEPTH - 1) begin : g_tail
            assign right_slot = '0;
        end else begin : g_mid
            assign right_slot = cell_q[i+1];
        end

        tprs_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .left_slot  (left_slot),
            .left_gt    (left_gt),
            .right_slot (right_slot),
            .cell_slot  (cell_q[i]),
            .cell_gt    (cell_gt[i])
        );
    end

    // ---------------- checks
    a_emit_has_run: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> count_reg != '0)
        else $error("emitting with no buffered pixel");

    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_step |-> cell_q[0].valid)
        else $error("emitting from an empty head cell");

    a_accept_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ACCEPT |-> count_reg < tprs_pkg::CNT_W'(tprs_pkg::RUN_DEPTH))
        else $error("chain full while accepting");

    a_chain_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACCEPT && $past(state_reg) == ST_EMIT) |-> !cell_q[0].valid)
        else $error("chain not empty after run emission");

endmodule

[bench/tb_threshold_pixel_run_sorter.sv]
`timescale 1ns / 1ps

module tb_threshold_pixel_run_sorter;

    localparam int CYCLE_LIMIT   = 200000;
    // idle wait after draining so the sort chain can settle after the last transfer
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT      = 8;
    // decodes to no register; a write there must change nothing
    localparam logic [tprs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Tracks the threshold, the run limit and the open run, and keeps the
    // pixels due out of the block in order.
    class run_sort_scoreboard;
        logic [tprs_pkg::THR_W-1:0] threshold;
        logic [tprs_pkg::LIM_W-1:0] run_limit;
        logic [tprs_pkg::PIX_W-1:0] open_run[$];
        tprs_pkg::out_item_t        sorted_due[$];
        int                         errors;

        function new();
            threshold = tprs_pkg::THRESHOLD_RESET;
            run_limit = tprs_pkg::MAX_RUN_RESET;
            errors    = 0;
        endfunction

        static function int unsigned luma(logic [tprs_pkg::PIX_W-1:0] p);
            return (32'(p[23:16]) * 11 + 32'(p[15:8]) * 16 + 32'(p[7:0]) * 5) >> 5;
        endfunction

        function void write_reg(logic [tprs_pkg::CFG_IDX_W-1:0] idx,
                                logic [tprs_pkg::CFG_DAT_W-1:0] data);
            if (idx == tprs_pkg::REG_THRESHOLD) begin
                threshold = data;
            end else if (idx == tprs_pkg::REG_MAX_RUN) begin
                run_limit = data[tprs_pkg::LIM_W-1:0];
            end
        endfunction

        // one input transfer: pass through, buffer, or close and emit the run
        function void note_pixel(tprs_pkg::in_item_t item);
            logic [tprs_pkg::PIX_W-1:0] run_sorted[$];
            tprs_pkg::out_item_t        res;
            int unsigned                lim, j;
            logic                       bright;
            bright = luma(item.pixel_argb) > threshold;
            lim = (run_limit == 0) ? 1 :
                  (run_limit > tprs_pkg::RUN_DEPTH) ? tprs_pkg::RUN_DEPTH : run_limit;
            if (open_run.size() == 0 && !bright) begin
                res.out_pixel     = item.pixel_argb;
                res.last_of_burst = 1'b1;
                res.out_row_end   = item.row_end;
                sorted_due.push_back(res);
                return;
            end
            if (open_run.size() < tprs_pkg::RUN_DEPTH) open_run.push_back(item.pixel_argb);
            if (bright && !item.row_end && open_run.size() < lim &&
                open_run.size() < tprs_pkg::RUN_DEPTH) return;
            // stable: a pixel goes after every earlier one of equal gray
            foreach (open_run[i]) begin
                j = run_sorted.size();
                while (j > 0 && luma(run_sorted[j-1]) > luma(open_run[i])) j--;
                run_sorted.insert(j, open_run[i]);
            end
            foreach (run_sorted[i]) begin
                res.out_pixel     = run_sorted[i];
                res.last_of_burst = (i == run_sorted.size() - 1);
                res.out_row_end   = res.last_of_burst ? item.row_end : 1'b0;
                sorted_due.push_back(res);
            end
            open_run.delete();
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(tprs_pkg::out_item_t got);
            tprs_pkg::out_item_t want;
            if (sorted_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result pixel %h", got.out_pixel));
                return;
            end
            want = sorted_due.pop_front();
            if (got.out_pixel !== want.out_pixel)
                report_mismatch($sformatf("out_pixel %h, want %h",
                                          got.out_pixel, want.out_pixel));
            if (got.last_of_burst !== want.last_of_burst)
                report_mismatch($sformatf("last_of_burst %b, want %b on pixel %h",
                                          got.last_of_burst, want.last_of_burst,
                                          want.out_pixel));
            if (got.out_row_end !== want.out_row_end)
                report_mismatch($sformatf("out_row_end %b, want %b on pixel %h",
                                          got.out_row_end, want.out_row_end,
                                          want.out_pixel));
        endtask
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    tprs_pkg::in_item_t             s_payload;
    logic                           m_valid;
    logic                           m_ready;
    tprs_pkg::out_item_t            m_payload;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [tprs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tprs_pkg::CFG_DAT_W-1:0] cfg_wdata;

    logic                           idle_on;          // random stalls on both channels
    int unsigned                    cycle_count = 0;
    run_sort_scoreboard             sb;

    threshold_pixel_run_sorter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Result side: backpressure changes on the falling edge only.
    always @(negedge aclk) begin
        m_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end

    // Result transfers are sampled on the rising edge, before the block's
    // registers update in this step.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_payload);
    end

    // Hang guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL threshold_pixel_run_sorter");
            $finish;
        end
    end

    // Gray pixel: r = g = b = level, so its brightness is exactly level.
    function automatic logic [tprs_pkg::PIX_W-1:0] shade(input logic [7:0] level,
                                                         input logic [7:0] alpha);
        return {alpha, level, level, level};
    endfunction

    // Mostly pixels above the threshold so runs form; some dark ones to
    // close them, some fully random, some right at the threshold for ties.
    function automatic logic [tprs_pkg::PIX_W-1:0] random_pixel(
        input logic [tprs_pkg::THR_W-1:0] thr);
        int unsigned pick, lo, hi;
        pick = $urandom_range(0, 9);
        lo   = 0;
        hi   = 255;
        if (pick < 2) return $urandom;
        if (pick < 7) begin
            lo = (thr == 255) ? 255 : thr + 1;
        end else if (pick < 9) begin
            hi = thr;
        end else begin
            lo = (thr < 2) ? 0 : thr - 2;
            hi = (thr > 253) ? 255 : thr + 2;
        end
        return shade(8'($urandom_range(lo, hi)), 8'($urandom));
    endfunction

    // Called and returns on a falling edge. Valid stays high on return so
    // back-to-back transfers need no lowering in between.
    task automatic send_pixel(input logic [tprs_pkg::PIX_W-1:0] pix, input logic rend);
        tprs_pkg::in_item_t item;
        item.pixel_argb = pix;
        item.row_end    = rend;
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_payload <= item;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(item);
        @(negedge aclk);
    endtask

    // One register write; the extra edge keeps valid low between writes so a
    // following write never lowers and raises it in the same step.
    task automatic program_reg(input logic [tprs_pkg::CFG_IDX_W-1:0] idx,
                               input logic [tprs_pkg::CFG_DAT_W-1:0] data);
        cfg_index <= idx;
        cfg_wdata <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Stop the input, wait for every pending result, then let a buffered
    // pixel finish its way into the chain.
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (sb.sorted_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int unsigned                    row_left, n_items;
        logic [tprs_pkg::CFG_DAT_W-1:0] thr, lim;
        logic [tprs_pkg::PIX_W-1:0]     pix;
        logic                           rend;

        sb        = new();
        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = tprs_pkg::REG_THRESHOLD;
        cfg_wdata = '0;
        idle_on   = 1'b1;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed, reset settings: threshold 128, limit 50 ---
        send_pixel(32'h0000_0000, 1'b0);        // black passes through
        send_pixel(32'hFFFF_FFFF, 1'b1);        // white at row end: run of one
        // run 200, 150, 150 closed by red (gray 87); the 150 tie keeps order
        send_pixel(shade(8'd200, 8'h11), 1'b0);
        send_pixel(shade(8'd150, 8'h22), 1'b0);
        send_pixel(shade(8'd150, 8'h33), 1'b0);
        send_pixel(32'h00FF_0000, 1'b0);
        send_pixel(32'h5A00_FF00, 1'b1);        // green, gray 127: dark at row end
        drain_and_settle();

        // limit zero acts as one: each bright pixel closes at once
        program_reg(tprs_pkg::REG_MAX_RUN, 8'd0);
        send_pixel(shade(8'd255, 8'hA5), 1'b0);
        send_pixel(shade(8'd129, 8'h5A), 1'b0);
        send_pixel(shade(8'd128, 8'h00), 1'b0); // equal to threshold: not bright
        drain_and_settle();

        // limit lowered while a run is open: closes on the next pixel
        program_reg(tprs_pkg::REG_MAX_RUN, 8'd50);
        for (int k = 0; k < 4; k++) send_pixel(shade(8'(250 - 20 * k), 8'(k)), 1'b0);
        drain_and_settle();
        program_reg(tprs_pkg::REG_MAX_RUN, 8'd2);
        send_pixel(shade(8'd210, 8'hC3), 1'b0);
        drain_and_settle();

        // unused index must leave the threshold at 128
        program_reg(REG_UNUSED, 8'h00);
        send_pixel(shade(8'd100, 8'h77), 1'b0);
        drain_and_settle();

        // threshold extremes
        program_reg(tprs_pkg::REG_THRESHOLD, 8'd255);
        send_pixel(32'hFFFF_FFFF, 1'b0);        // nothing exceeds 255
        drain_and_settle();
        program_reg(tprs_pkg::REG_THRESHOLD, 8'd0);
        send_pixel(32'hFF00_0000, 1'b0);        // gray 0 stays dark
        send_pixel(32'h0000_0020, 1'b1);        // gray 5, bright, closes at row end
        drain_and_settle();

        // --- random rows, settings changed between phases ---
        row_left = 0;
        for (int ph = 0; ph < 11; ph++) begin
            drain_and_settle();
            case (ph)
                0: begin                        // limit 127 saturates at the depth
                    thr = 8'd0;
                    lim = 8'hFF;
                end
                1: begin
                    thr = 8'd255;
                    lim = 8'd1;
                end
                2: begin
                    thr = 8'd128;
                    lim = 8'd0;
                end
                3: begin
                    thr = 8'd100;
                    lim = 8'd64;
                end
                default: begin
                    thr = 8'($urandom_range(0, 255));
                    lim = $urandom_range(0, 1) ? 8'($urandom_range(1, 8))
                                               : 8'($urandom_range(0, 255));
                end
            endcase
            program_reg(tprs_pkg::REG_THRESHOLD, thr);
            program_reg(tprs_pkg::REG_MAX_RUN, lim);
            // phases 4 and 5 run with no stalls at all
            idle_on <= (ph != 4 && ph != 5);
            n_items = (ph == 0) ? 70 : 26;
            for (int i = 0; i < n_items; i++) begin
                if (row_left == 0) row_left = (ph == 0) ? 70 : $urandom_range(1, 40);
                // phase 0: one long all-bright row to fill the whole buffer
                pix = (ph == 0) ? shade(8'($urandom_range(1, 255)), 8'($urandom))
                                : random_pixel(sb.threshold);
                row_left--;
                rend = (row_left == 0) || (ph == 10 && i == n_items - 1);
                send_pixel(pix, rend);
            end
        end

        drain_and_settle();
        if (sb.errors == 0) begin
            $display("PASS threshold_pixel_run_sorter");
        end else begin
            $display("FAIL threshold_pixel_run_sorter");
        end
        $finish;
    end

endmodule
